// File: rtl/pdst_pkg.sv
// package for the proper divisor sum / perfect number test block
// holds widths and the sequencer state type; no dependencies
package pdst_pkg;

  // input word and number widths
  localparam int IN_WIDTH     = 32;
  localparam int NUM_WIDTH    = 32;
  // result field width and padded output word width
  localparam int TOTAL_WIDTH  = 35;
  localparam int OUT_WIDTH    = ((TOTAL_WIDTH + 1 + 7) / 8) * 8;
  // trial divisor reaches 2^(NUM_WIDTH/2), one bit above half the number width
  localparam int DIV_WIDTH    = (NUM_WIDTH + 1) / 2 + 1;
  // running sum has headroom over the number
  localparam int ACC_WIDTH    = NUM_WIDTH + 4;
  localparam int CNT_WIDTH    = $clog2(NUM_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

// File: rtl/proper_divisor_sum_perfect_test.sv
// top level of the proper divisor sum / perfect number test block
// one bit-serial restoring divider shared by every trial divisor
// depends on pdst_pkg
//
// Takes one unsigned number per input word and returns one word with the sum
// of its proper divisors and a perfect flag. Trial divisors d run from 2 while
// d <= n/d; each trial runs NUM_WIDTH divider steps plus one check/accumulate
// step, and the last trial, whose divisor is past the root, runs the same.
// The shared divider makes the time per item grow with the square root of n;
// numbers below 2 skip the divider. s_tready is high only between items; a
// finished result sits in the output register and the next number can be
// taken while it waits. Sums that would not fit 35 bits saturate to all ones.
module proper_divisor_sum_perfect_test (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pdst_pkg::IN_WIDTH-1:0] s_tdata,   // [31:0] number
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pdst_pkg::OUT_WIDTH-1:0] m_tdata   // [34:0] divisor_total, [35] is_perfect
);
  import pdst_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [NUM_WIDTH-1:0]   num;
  logic [NUM_WIDTH-1:0]   quo;
  logic [DIV_WIDTH-1:0]   rem;
  logic [DIV_WIDTH-1:0]   dvs;
  logic [CNT_WIDTH-1:0]   cnt;
  logic [ACC_WIDTH-1:0]   total;
  logic [TOTAL_WIDTH-1:0] out_total;
  logic                   out_perfect;

  logic [NUM_WIDTH-1:0]   num_in;
  logic [DIV_WIDTH:0]     shifted;
  logic                   fits;
  logic                   past_root;
  logic [ACC_WIDTH-1:0]   cofactor_add;
  logic                   out_free;
  logic                   accept;

  assign num_in    = NUM_WIDTH'(s_tdata);
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // one restoring division step: bring down the next dividend bit
  assign shifted   = {rem, quo[NUM_WIDTH-1]};
  assign fits      = (shifted >= {1'b0, dvs});
  // loop ends once the divisor passes the quotient
  assign past_root = (NUM_WIDTH'(dvs) > quo);
  assign cofactor_add = (quo != NUM_WIDTH'(dvs)) ? ACC_WIDTH'(quo) : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (num_in < NUM_WIDTH'(2)) ? ST_DONE : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (cnt == '0) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = past_root ? ST_DONE : ST_DIVIDE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      cnt <= cnt - 1'b1;
    end else begin
      cnt <= CNT_WIDTH'(NUM_WIDTH - 1);
    end
  end

  // datapath: divisor, quotient/remainder, running sum
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          num   <= num_in;
          quo   <= num_in;
          rem   <= '0;
          dvs   <= DIV_WIDTH'(2);
          total <= (num_in < NUM_WIDTH'(2)) ? '0 : ACC_WIDTH'(1);
        end
      end
      ST_DIVIDE: begin
        quo <= {quo[NUM_WIDTH-2:0], fits};
        rem <= fits ? DIV_WIDTH'(shifted - {1'b0, dvs}) : shifted[DIV_WIDTH-1:0];
      end
      ST_CHECK: begin
        if (!past_root) begin
          if (rem == '0) begin
            total <= total + ACC_WIDTH'(dvs) + cofactor_add;
          end
          dvs <= dvs + 1'b1;
          quo <= num;
          rem <= '0;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_total   <= (|total[ACC_WIDTH-1:TOTAL_WIDTH]) ? '1 : total[TOTAL_WIDTH-1:0];
      out_perfect <= (num != '0) && (total == ACC_WIDTH'(num));
    end
  end

  assign m_tdata = {(OUT_WIDTH - TOTAL_WIDTH - 1)'(0), out_perfect, out_total};

`ifndef SYNTHESIS
  // remainder of a finished division is below the divisor
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> rem < dvs)
    else $error("remainder not below divisor");

  // trial divisors start at two
  a_dvs_min: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> dvs >= DIV_WIDTH'(2))
    else $error("trial divisor below two");

  // the divider runs all its steps before the check
  a_divide_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE && cnt != '0 |=> state == ST_DIVIDE)
    else $error("division cut short");

  // a perfect number never has a zero sum
  a_perfect_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_perfect |-> out_total != '0)
    else $error("perfect flag with zero sum");
`endif

endmodule

// File: tb/tb_proper_divisor_sum_perfect_test.sv
// testbench for proper_divisor_sum_perfect_test: streams numbers in, checks each
// divisor sum and perfect flag against a behavioral predictor, in order
// depends on pdst_pkg and rtl/proper_divisor_sum_perfect_test.sv
module tb_proper_divisor_sum_perfect_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pdst_pkg::*;

  localparam int RESET_CYCLES = 8;
  // long enough for the largest 32-bit number, with no word moving
  localparam int IDLE_LIMIT   = 8_000_000;
  localparam int FIRST_HOLD   = 2000;
  localparam int LATE_HOLD    = 30000;
  localparam int LATE_HOLD_AT = 50;
  localparam int RANDOM_ITEMS = 76;
  localparam int DRAIN_CYCLES = 64;
  localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_WIDTH) - 1;

  typedef struct packed {
    logic [TOTAL_WIDTH-1:0] total;
    logic                   perfect;
  } divisor_sum_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_WIDTH-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_WIDTH-1:0] m_tdata;

  logic [IN_WIDTH-1:0] pending_numbers[$];
  divisor_sum_t        expected_sums[$];
  divisor_sum_t        want;
  bit                  in_taken = 1'b0;
  bit                  out_taken = 1'b0;
  int                  tx_wait = 0;
  int                  tx_count = 0;
  int                  rx_wait = FIRST_HOLD;
  int                  results_seen = 0;
  int                  idle_cycles = 0;
  int                  errors = 0;

  proper_divisor_sum_perfect_test dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic divisor_sum_t predict_divisor_sum(input logic [IN_WIDTH-1:0] word);
    longint unsigned n;
    longint unsigned sum;
    longint unsigned d;
    longint unsigned co;
    divisor_sum_t    r;
    n = 64'(word) & ((64'd1 << NUM_WIDTH) - 1);
    sum = 0;
    if (n >= 2) begin
      sum = 1;
      for (d = 2; d <= n / d; d++) begin
        if (n % d == 0) begin
          co = n / d;
          sum += d;
          // a square root divides only once
          if (co != d) sum += co;
        end
      end
    end
    r.total = (sum > TOTAL_MAX) ? '1 : sum[TOTAL_WIDTH-1:0];
    r.perfect = (n != 0) && (sum == n);
    return r;
  endfunction

  // mostly cheap numbers: the block's time grows with the square root
  function automatic logic [IN_WIDTH-1:0] random_number();
    int unsigned k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 1023);
      4, 5: return $urandom_range(0, 65535);
      6: begin
        k = $urandom_range(2, 300);
        return k * k;
      end
      7: begin
        case ($urandom_range(0, 3))
          0: k = 6;
          1: k = 28;
          2: k = 496;
          default: k = 8128;
        endcase
        return k + $urandom_range(0, 2) - 1;
      end
      8: return $urandom_range(0, (1 << 20) - 1);
      default: return 32'd1 << $urandom_range(0, 19);
    endcase
  endfunction

  // every third stretch of 16 words runs with no idling
  function automatic int next_gap(input int count);
    if ((count / 16) % 3 == 2) return 0;
    return $urandom_range(0, 11);
  endfunction

  // sender: at most one nonblocking write of s_tvalid per step
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // word still on offer
    end else if (tx_wait > 0) begin
      s_tvalid <= 1'b0;
      tx_wait = tx_wait - 1;
    end else if (pending_numbers.size() > 0) begin
      s_tdata <= pending_numbers.pop_front();
      s_tvalid <= 1'b1;
      tx_wait = next_gap(tx_count);
      tx_count++;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // receiver: random stalls plus two long hold-offs so the block backs up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tready && out_taken) begin
        if (results_seen == LATE_HOLD_AT) rx_wait = LATE_HOLD;
        else rx_wait = next_gap(results_seen);
      end
      if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait = rx_wait - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      in_taken = s_tvalid && s_tready;
      out_taken = m_tvalid && m_tready;
      if (in_taken) expected_sums.push_back(predict_divisor_sum(s_tdata));
      if (out_taken) begin
        results_seen++;
        if (expected_sums.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, got total %0d perfect %0b", $time,
                   m_tdata[TOTAL_WIDTH-1:0], m_tdata[TOTAL_WIDTH]);
        end else begin
          want = expected_sums.pop_front();
          if (m_tdata[TOTAL_WIDTH-1:0] !== want.total) begin
            errors++;
            $display("%0t: divisor_total expected %0d got %0d", $time, want.total,
                     m_tdata[TOTAL_WIDTH-1:0]);
          end
          if (m_tdata[TOTAL_WIDTH] !== want.perfect) begin
            errors++;
            $display("%0t: is_perfect expected %0b got %0b", $time, want.perfect,
                     m_tdata[TOTAL_WIDTH]);
          end
        end
      end
      if (in_taken || out_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    // zero, one, primes, squares, perfect numbers, powers of two, all ones
    pending_numbers = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd8, 32'd9,
                        32'd12, 32'd16, 32'd25, 32'd28, 32'd36, 32'd97, 32'd120,
                        32'd496, 32'd1024, 32'd8128, 32'd65521, 32'd65536, 32'd65537,
                        32'd33550336, 32'hFFFF_FFFF};
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_numbers.push_back(random_number());
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    do @(posedge clk);
    while (pending_numbers.size() > 0 || s_tvalid || expected_sums.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
